/* rtl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes of the max-tracking stack: item layouts, operation
// and status codes, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int DATA_W    = 32;
    localparam int ENTRIES_W = 9;
    localparam int DEPTH     = 256;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic signed [DATA_W-1:0] max_value;
        logic                     max_valid;
        logic [1:0]               status;
        logic [ENTRIES_W-1:0]     entries;
    } rsp_item_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } state_t;

endpackage

`default_nettype wire

/* rtl/mts_ram.sv */
// ----------------------------------------------------------------------------
// mts_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/max_tracking_stack.sv */
// ----------------------------------------------------------------------------
// max_tracking_stack
// Bounded LIFO stack of signed values that reports its current maximum.
//
// Requests arrive on req (opcode, value) under req_valid/req_ready; each
// request gives exactly one response on rsp under rsp_valid/rsp_ready.
// All entries live in two RAMs (values and running maxima); the two tops are
// cached in registers. Push and query results are registered at the accept
// edge. A pop reads the entries under the tops from both RAMs, so its
// result is registered from the RAM read data in the fetch state.
// One request is in flight at a time; a pop holds off the next request
// until its RAM read data are registered into the response.
// req_ready is high when no pop read is pending and the response register is
// empty or being drained in the same cycle, so a stalled receiver holds the
// response and blocks new requests. Reset empties both stacks at once; the
// RAM contents are not cleared, since only entries below the counts are read.
// ----------------------------------------------------------------------------
`default_nettype none

module max_tracking_stack #(
    parameter int DEPTH = mts_pkg::DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire mts_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output mts_pkg::rsp_item_t      rsp
);

    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W    = mts_pkg::DATA_W;
    localparam int ENTRIES_W = mts_pkg::ENTRIES_W;

    mts_pkg::state_t          state_reg, state_next;
    logic [COUNT_W-1:0]       value_count_reg, value_count_next;
    logic [COUNT_W-1:0]       max_count_reg, max_count_next;
    logic signed [DATA_W-1:0] top_value_reg, top_value_next;
    logic signed [DATA_W-1:0] top_max_reg, top_max_next;
    mts_pkg::rsp_item_t       rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic                     accept;
    logic                     not_empty;
    logic [COUNT_W-1:0]       count_minus2;
    logic [COUNT_W-1:0]       max_minus1;
    logic                     pop_max;

    logic                     vmem_we, mmem_we, mem_re;
    logic [ADDR_W-1:0]        vmem_raddr, mmem_raddr;
    logic [DATA_W-1:0]        vmem_rdata, mmem_rdata;

    assign req_ready = (state_reg == mts_pkg::S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign not_empty = (value_count_reg != '0);

    // A pop reads the entries that become the new tops.
    assign count_minus2 = value_count_reg - COUNT_W'(2);
    assign pop_max      = (max_count_reg != '0) && (top_value_reg == top_max_reg);
    assign max_minus1   = max_count_reg - (pop_max ? COUNT_W'(2) : COUNT_W'(1));
    assign vmem_raddr   = count_minus2[ADDR_W-1:0];
    assign mmem_raddr   = max_minus1[ADDR_W-1:0];
    assign mem_re       = accept && (req.opcode == mts_pkg::OP_POP);

    assign vmem_we = accept && (req.opcode == mts_pkg::OP_PUSH)
                     && (value_count_reg != COUNT_W'(DEPTH));
    assign mmem_we = vmem_we && ((max_count_reg == '0) || (req.value >= top_max_reg));

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (vmem_we),
        .waddr (value_count_reg[ADDR_W-1:0]),
        .wdata (req.value),
        .re    (mem_re),
        .raddr (vmem_raddr),
        .rdata (vmem_rdata)
    );

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_max_ram (
        .clk   (clk),
        .we    (mmem_we),
        .waddr (max_count_reg[ADDR_W-1:0]),
        .wdata (req.value),
        .re    (mem_re),
        .raddr (mmem_raddr),
        .rdata (mmem_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        value_count_next = value_count_reg;
        max_count_next   = max_count_reg;
        top_value_next   = top_value_reg;
        top_max_next     = top_max_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            mts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        mts_pkg::OP_PUSH:
                        begin
                            rsp_valid_next = 1'b1;
                            if (vmem_we)
                            begin
                                value_count_next = value_count_reg + COUNT_W'(1);
                                top_value_next   = req.value;
                                if (mmem_we)
                                begin
                                    max_count_next = max_count_reg + COUNT_W'(1);
                                    top_max_next   = req.value;
                                end
                                rsp_next.data_out  = req.value;
                                rsp_next.max_value = mmem_we ? req.value : top_max_reg;
                                rsp_next.max_valid = 1'b1;
                                rsp_next.status    = mts_pkg::ST_OK;
                                rsp_next.entries   = ENTRIES_W'(value_count_next);
                            end
                            else
                            begin
                                // Full: refused, stack left as it is.
                                rsp_next.data_out  = top_value_reg;
                                rsp_next.max_value = top_max_reg;
                                rsp_next.max_valid = 1'b1;
                                rsp_next.status    = mts_pkg::ST_FULL;
                                rsp_next.entries   = ENTRIES_W'(value_count_reg);
                            end
                        end
                        mts_pkg::OP_POP:
                        begin
                            if (not_empty)
                            begin
                                // The response completes once the new tops are read.
                                state_next         = mts_pkg::S_FETCH;
                                value_count_next   = value_count_reg - COUNT_W'(1);
                                if (pop_max)
                                begin
                                    max_count_next = max_count_reg - COUNT_W'(1);
                                end
                                rsp_next.data_out  = top_value_reg;
                                rsp_next.max_value = '0;
                                rsp_next.max_valid = (value_count_next != '0);
                                rsp_next.status    = mts_pkg::ST_OK;
                                rsp_next.entries   = ENTRIES_W'(value_count_next);
                            end
                            else
                            begin
                                rsp_valid_next     = 1'b1;
                                rsp_next.data_out  = '0;
                                rsp_next.max_value = '0;
                                rsp_next.max_valid = 1'b0;
                                rsp_next.status    = mts_pkg::ST_EMPTY;
                                rsp_next.entries   = '0;
                            end
                        end
                        default:
                        begin
                            // Query; the unused opcode behaves the same.
                            rsp_valid_next     = 1'b1;
                            rsp_next.data_out  = not_empty ? top_value_reg : '0;
                            rsp_next.max_value = not_empty ? top_max_reg : '0;
                            rsp_next.max_valid = not_empty;
                            rsp_next.status    = not_empty ? mts_pkg::ST_OK : mts_pkg::ST_EMPTY;
                            rsp_next.entries   = ENTRIES_W'(value_count_reg);
                        end
                    endcase
                end
            end
            mts_pkg::S_FETCH:
            begin
                state_next     = mts_pkg::S_IDLE;
                rsp_valid_next = 1'b1;
                top_value_next = vmem_rdata;
                top_max_next   = mmem_rdata;
                rsp_next.max_value = not_empty ? $signed(mmem_rdata) : '0;
            end
            default:
            begin
                state_next = mts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mts_pkg::S_IDLE;
            value_count_reg <= '0;
            max_count_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            value_count_reg <= value_count_next;
            max_count_reg   <= max_count_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_value_reg <= top_value_next;
        top_max_reg   <= top_max_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The max stack never holds more entries than the value stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        max_count_reg <= value_count_reg)
        else $error("max stack deeper than value stack");

    // A non-empty value stack always has a recorded maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (value_count_reg != '0) |-> (max_count_reg != '0))
        else $error("non-empty stack without a maximum");

    // A pop read always completes into a pending response on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mts_pkg::S_FETCH) |=> (state_reg == mts_pkg::S_IDLE) && rsp_valid_reg)
        else $error("pop response not delivered after read");

    // The max_valid flag of a response matches its entry count.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.max_valid == (rsp_reg.entries != '0)))
        else $error("max_valid disagrees with entries");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the max-tracking stack. A queue of operations is
// built up front (a directed opening, then random walks, a fill past full and
// a drain past empty) and offered by a clocked driver with random gaps. A
// shadow stack with its own running-max stack predicts every response, and a
// clocked monitor with random back-pressure checks each response field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int DATA_W    = mts_pkg::DATA_W;
    localparam int DEPTH     = mts_pkg::DEPTH;
    localparam int ENTRIES_W = mts_pkg::ENTRIES_W;

    // Opcode 3 has no meaning of its own; the block treats it as a query.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] V_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        mts_pkg::req_item_t item;
        int unsigned        gap;
        bit                 sync;
    } pending_op_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    mts_pkg::req_item_t req = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    mts_pkg::rsp_item_t rsp;

    max_tracking_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow stack: values plus the stack of running maxima.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] val_stk [DEPTH];
    logic signed [DATA_W-1:0] max_stk [DEPTH];
    int val_depth = 0;
    int max_depth = 0;
    int n_push = 0, n_pop = 0, n_query = 0, n_full = 0, n_empty = 0, peak_depth = 0;

    function automatic mts_pkg::rsp_item_t stack_step(mts_pkg::req_item_t r);
        mts_pkg::rsp_item_t       o;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] popped;
        logic                     did_pop;
        o       = '0;
        v       = r.value;
        popped  = '0;
        did_pop = 1'b0;
        o.status = mts_pkg::ST_OK;
        case (r.opcode)
            mts_pkg::OP_PUSH:
            begin
                n_push++;
                if (val_depth >= DEPTH)
                begin
                    o.status = mts_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    if (max_depth == 0 || v >= max_stk[max_depth-1])
                    begin
                        max_stk[max_depth] = v;
                        max_depth++;
                    end
                    val_stk[val_depth] = v;
                    val_depth++;
                end
            end
            mts_pkg::OP_POP:
            begin
                n_pop++;
                if (val_depth == 0)
                begin
                    o.status = mts_pkg::ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    popped  = val_stk[val_depth-1];
                    did_pop = 1'b1;
                    if (max_depth > 0 && popped == max_stk[max_depth-1])
                        max_depth--;
                    val_depth--;
                end
            end
            default:
            begin
                n_query++;
                if (val_depth == 0)
                begin
                    o.status = mts_pkg::ST_EMPTY;
                    n_empty++;
                end
            end
        endcase
        if (val_depth > peak_depth)
            peak_depth = val_depth;
        if (did_pop)
            o.data_out = popped;
        else
            o.data_out = (val_depth > 0) ? val_stk[val_depth-1] : '0;
        o.max_value = (val_depth > 0) ? max_stk[max_depth-1] : '0;
        o.max_valid = (val_depth > 0);
        o.entries   = val_depth[ENTRIES_W-1:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Operation list and its generation.
    // ------------------------------------------------------------------
    pending_op_t        op_q[$];
    mts_pkg::rsp_item_t due_rsp_q[$];
    int                 gen_depth = 0;
    int                 n_items = 0;
    bit                 sync_next = 1'b0;
    bit                 quiet = 1'b0;
    int                 n_errors = 0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Small values collide often, which exercises ties with the current max.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        else if (r < 7)
            return $signed($urandom_range(0, 15)) - 8;
        else if (r < 9)
            case ($urandom_range(0, 3))
                0: return V_MAX;
                1: return V_MIN;
                2: return '0;
                default: return '1;
            endcase
        else
            return V_MAX - $urandom_range(0, 3);
    endfunction

    task automatic add_op(logic [1:0] op, logic signed [DATA_W-1:0] v);
        pending_op_t p;
        p.item.opcode = op;
        p.item.value  = v;
        p.gap         = pick_gap();
        p.sync        = sync_next;
        sync_next     = 1'b0;
        op_q.push_back(p);
        n_items++;
        if (op == mts_pkg::OP_PUSH && gen_depth < DEPTH)
            gen_depth++;
        else if (op == mts_pkg::OP_POP && gen_depth > 0)
            gen_depth--;
    endtask

    task automatic random_walk(int n, int push_pct);
        int unsigned r;
        logic [1:0]  op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < 12)
                op = mts_pkg::OP_QUERY;
            else if ($urandom_range(0, 99) < push_pct)
                op = mts_pkg::OP_PUSH;
            else
                op = mts_pkg::OP_POP;
            add_op(op, pick_value());
        end
    endtask

    // ------------------------------------------------------------------
    // Driver.
    // ------------------------------------------------------------------
    int idle_run = 0;
    int in_flight = 0;
    int n_req = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic offer;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            idle_run  = 0;
            in_flight = 0;
        end
        else
        begin
            offer = req_valid;
            if (rsp_valid && rsp_ready)
                in_flight--;
            if (req_valid && req_ready)
            begin
                due_rsp_q.push_back(stack_step(req));
                in_flight++;
                n_req++;
                offer = 1'b0;
            end
            if (!offer && op_q.size() != 0)
            begin
                if (idle_run >= op_q[0].gap && (!op_q[0].sync || in_flight == 0))
                begin
                    req      <= op_q[0].item;
                    op_q.pop_front();
                    offer    = 1'b1;
                    idle_run = 0;
                end
                else
                    idle_run++;
            end
            req_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Monitor with random back-pressure.
    // ------------------------------------------------------------------
    int n_rsp = 0;
    int stall_left = 0;
    int calm_left = 0;
    bit held_off = 1'b0;

    task automatic show_diff(string field, longint want, longint got);
        n_errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mts_pkg::rsp_item_t want;
        logic               ready_nxt;
        int unsigned        r;
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_rsp++;
                if (due_rsp_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: response with nothing expected: %p", $time, rsp);
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp.data_out !== want.data_out)
                        show_diff("data_out", want.data_out, rsp.data_out);
                    if (rsp.max_value !== want.max_value)
                        show_diff("max_value", want.max_value, rsp.max_value);
                    if (rsp.max_valid !== want.max_valid)
                        show_diff("max_valid", want.max_valid, rsp.max_valid);
                    if (rsp.status !== want.status)
                        show_diff("status", want.status, rsp.status);
                    if (rsp.entries !== want.entries)
                        show_diff("entries", want.entries, rsp.entries);
                end
            end
            ready_nxt = 1'b1;
            // One long hold-off while the sender keeps an item waiting.
            if (!held_off && n_rsp >= HOLD_AT && req_valid)
            begin
                held_off   = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_nxt = 1'b0;
            end
            else if (calm_left > 0)
                calm_left--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    calm_left = $urandom_range(40, 120);
                else if (r < 14)
                    stall_left = $urandom_range(1, 3);
                else if (r < 17)
                    stall_left = $urandom_range(4, 12);
                else if (r < 18)
                    stall_left = $urandom_range(30, 90);
            end
            rsp_ready <= ready_nxt;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no handshake on either side.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int directed;

        // Directed opening: empty cases, extremes, ties with the max.
        add_op(mts_pkg::OP_QUERY, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(OP_UNUSED, $urandom);
        add_op(mts_pkg::OP_PUSH, '0);
        add_op(mts_pkg::OP_PUSH, V_MIN);
        add_op(mts_pkg::OP_PUSH, V_MAX);
        add_op(mts_pkg::OP_PUSH, V_MAX);
        add_op(mts_pkg::OP_QUERY, $urandom);
        add_op(OP_UNUSED, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_PUSH, '1);
        add_op(mts_pkg::OP_PUSH, {DATA_W/2{2'b10}});
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_PUSH, -5);
        add_op(mts_pkg::OP_PUSH, -5);
        add_op(mts_pkg::OP_PUSH, -7);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        directed = n_items;

        sync_next = 1'b1;
        random_walk(200, 60);
        quiet = 1'b1;
        random_walk(60, 55);
        quiet = 1'b0;

        // Fill to the limit, then push against a full stack.
        sync_next = 1'b1;
        while (gen_depth < DEPTH)
            add_op(mts_pkg::OP_PUSH, pick_value());
        for (int i = 0; i < 3; i++)
            add_op(mts_pkg::OP_PUSH, pick_value());
        add_op(mts_pkg::OP_QUERY, $urandom);
        random_walk(60, 40);

        // Drain completely, then pop an empty stack.
        while (gen_depth > 0)
            add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        add_op(mts_pkg::OP_POP, $urandom);
        sync_next = 1'b1;

        while (n_items - directed < RANDOM_ITEMS)
            random_walk(40, $urandom_range(30, 70));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (op_q.size() != 0 || req_valid || due_rsp_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (due_rsp_q.size() != 0)
        begin
            n_errors += due_rsp_q.size();
            $display("%0t: %0d responses never arrived", $time, due_rsp_q.size());
        end
        $display("Ran %0d operations (%0d push, %0d pop, %0d query), %0d responses checked.",
                 n_req, n_push, n_pop, n_query, n_rsp);
        $display("Refused %0d pushes on full and %0d pops or queries on empty; deepest stack %0d.",
                 n_full, n_empty, peak_depth);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/max_tracking_stack.sv
test/tb_top.sv
